FILE: rtl/cdll_pkg.sv
// Shared constants and types for the circular doubly linked list engine.
`default_nettype none

package cdll_pkg;

  localparam int CAPACITY_DEFAULT   = 32;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int COMMAND_W = 2;
  localparam int VALUE_W   = 32;
  localparam int ELEMENT_W = 32;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 6;

  localparam logic [COMMAND_W-1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_INS_BACK  = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_DELETE    = 2'd2;
  localparam logic [COMMAND_W-1:0] CMD_READOUT   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_LISTED    = 3'd4
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/circular_linked_list_engine.sv
// Insert writes the new slot at acceptance and patches its neighbours' links in the link state.
// Delete walks the list one slot per cycle from the head, then unlinks the match in the fix state.
// Readout emits one beat per cycle from the walk state, paced by result_ready.
// A new command is taken only when the sequencer is idle; one result may still wait.
// Reset clears the length, head, tail and slot map; the slot memories keep their contents.
`default_nettype none

module circular_linked_list_engine
  import cdll_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [COMMAND_W-1:0] command,
  input  logic signed [VALUE_W-1:0] value,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic signed [ELEMENT_W-1:0] element,
  output logic [STATUS_W-1:0]  status,
  output logic [COUNT_W-1:0]   element_count,
  output logic                 last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LEN_W = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_INS_LINK = 5'b00010,
    ST_WALK     = 5'b00100,
    ST_DEL_FIX  = 5'b01000,
    ST_RESP     = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]      head_slot, head_slot_next;
  logic [IDX_W-1:0]      tail_slot, tail_slot_next;
  logic [LEN_W-1:0]      list_length, list_length_next;
  logic [IDX_W-1:0]      cur, cur_next;
  logic [LEN_W-1:0]      walk_count, walk_count_next;
  logic [COMMAND_W-1:0]  cmd, cmd_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  logic [IDX_W-1:0]      ins_slot, ins_slot_next;
  logic [IDX_W-1:0]      del_prev, del_prev_next;
  logic [IDX_W-1:0]      del_next, del_next_next;
  status_t               res_status, res_status_next;

  logic [DATA_WIDTH-1:0] value_dw;
  logic                  list_full;
  logic                  list_empty;
  logic                  walk_final;
  logic                  out_free;

  logic                  emit;
  logic [ELEMENT_W-1:0]  emit_element;
  status_t               emit_status;
  logic                  emit_last;

  logic                  val_we, nxt_we, prv_we;
  logic [IDX_W-1:0]      val_waddr, nxt_waddr, prv_waddr;
  logic [DATA_WIDTH-1:0] val_wdata;
  logic [IDX_W-1:0]      nxt_wdata, prv_wdata;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] val_rd;
  logic [IDX_W-1:0]      nxt_rd, prv_rd;

  logic                  map_set, map_clear;
  logic [IDX_W-1:0]      map_addr;
  logic [IDX_W-1:0]      free_slot;

  assign value_dw   = DATA_WIDTH'(value);
  assign list_full  = (list_length == LEN_W'(CAPACITY));
  assign list_empty = (list_length == '0);
  assign walk_final = ((walk_count + LEN_W'(1)) == list_length);
  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE);

  cdll_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk       (clk),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_we    (prv_we),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata),
    .rd_addr   (rd_addr),
    .val_rd    (val_rd),
    .nxt_rd    (nxt_rd),
    .prv_rd    (prv_rd)
  );

  cdll_slot_map #(
    .CAPACITY (CAPACITY)
  ) u_slot_map (
    .clk       (clk),
    .rst       (rst),
    .set       (map_set),
    .clear     (map_clear),
    .addr      (map_addr),
    .free_slot (free_slot)
  );

  always_comb begin
    state_next       = state;
    head_slot_next   = head_slot;
    tail_slot_next   = tail_slot;
    list_length_next = list_length;
    cur_next         = cur;
    walk_count_next  = walk_count;
    cmd_next         = cmd;
    key_next         = key;
    ins_slot_next    = ins_slot;
    del_prev_next    = del_prev;
    del_next_next    = del_next;
    res_status_next  = res_status;

    emit         = 1'b0;
    emit_element = '0;
    emit_status  = STATUS_DONE;
    emit_last    = 1'b1;

    val_we    = 1'b0;
    val_waddr = free_slot;
    val_wdata = value_dw;
    nxt_we    = 1'b0;
    nxt_waddr = free_slot;
    nxt_wdata = head_slot;
    prv_we    = 1'b0;
    prv_waddr = free_slot;
    prv_wdata = tail_slot;
    rd_addr   = cur;

    map_set   = 1'b0;
    map_clear = 1'b0;
    map_addr  = ins_slot;

    unique case (state)
      ST_IDLE: begin
        rd_addr = head_slot;
        if (item_valid) begin
          cmd_next        = command;
          key_next        = value_dw;
          cur_next        = head_slot;
          walk_count_next = '0;
          unique case (command) inside
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (list_full) begin
                res_status_next = STATUS_FULL;
                state_next      = ST_RESP;
              end else begin
                val_we        = 1'b1;
                nxt_we        = 1'b1;
                prv_we        = 1'b1;
                nxt_wdata     = list_empty ? free_slot : head_slot;
                prv_wdata     = list_empty ? free_slot : tail_slot;
                ins_slot_next = free_slot;
                state_next    = ST_INS_LINK;
              end
            end
            CMD_DELETE, CMD_READOUT: begin
              if (list_empty) begin
                res_status_next = STATUS_EMPTY;
                state_next      = ST_RESP;
              end else begin
                state_next = ST_WALK;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_INS_LINK: begin
        map_set          = 1'b1;
        map_addr         = ins_slot;
        list_length_next = list_length + LEN_W'(1);
        if (list_empty) begin
          head_slot_next = ins_slot;
          tail_slot_next = ins_slot;
        end else begin
          prv_we    = 1'b1;
          prv_waddr = head_slot;
          prv_wdata = ins_slot;
          nxt_we    = 1'b1;
          nxt_waddr = tail_slot;
          nxt_wdata = ins_slot;
          if (cmd == CMD_INS_FRONT) begin
            head_slot_next = ins_slot;
          end else begin
            tail_slot_next = ins_slot;
          end
        end
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          res_status_next = STATUS_DONE;
          state_next      = ST_RESP;
        end
      end

      ST_WALK: begin
        if (cmd == CMD_READOUT) begin
          if (out_free) begin
            emit         = 1'b1;
            emit_element = ELEMENT_W'(signed'(val_rd));
            emit_status  = STATUS_LISTED;
            emit_last    = walk_final;
            if (walk_final) begin
              state_next = ST_IDLE;
            end else begin
              rd_addr         = nxt_rd;
              cur_next        = nxt_rd;
              walk_count_next = walk_count + LEN_W'(1);
            end
          end
        end else if (val_rd == key) begin
          del_prev_next = prv_rd;
          del_next_next = nxt_rd;
          state_next    = ST_DEL_FIX;
        end else if (walk_final) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = STATUS_NOT_FOUND;
            state_next  = ST_IDLE;
          end else begin
            res_status_next = STATUS_NOT_FOUND;
            state_next      = ST_RESP;
          end
        end else begin
          rd_addr         = nxt_rd;
          cur_next        = nxt_rd;
          walk_count_next = walk_count + LEN_W'(1);
        end
      end

      ST_DEL_FIX: begin
        map_clear        = 1'b1;
        map_addr         = cur;
        list_length_next = list_length - LEN_W'(1);
        if (list_length == LEN_W'(1)) begin
          head_slot_next = '0;
          tail_slot_next = '0;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = del_prev;
          nxt_wdata = del_next;
          prv_we    = 1'b1;
          prv_waddr = del_next;
          prv_wdata = del_prev;
          if (cur == head_slot) begin
            head_slot_next = del_next;
          end
          if (cur == tail_slot) begin
            tail_slot_next = del_prev;
          end
        end
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          res_status_next = STATUS_DONE;
          state_next      = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = res_status;
          state_next  = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head_slot   <= '0;
      tail_slot   <= '0;
      list_length <= '0;
    end else begin
      state       <= state_next;
      head_slot   <= head_slot_next;
      tail_slot   <= tail_slot_next;
      list_length <= list_length_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    walk_count <= walk_count_next;
    cmd        <= cmd_next;
    key        <= key_next;
    ins_slot   <= ins_slot_next;
    del_prev   <= del_prev_next;
    del_next   <= del_next_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      element       <= emit_element;
      status        <= emit_status;
      element_count <= COUNT_W'(list_length_next);
      last          <= emit_last;
    end
  end

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    list_length <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_walk_in_list: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> walk_count < list_length)
    else $error("walk ran past the list length");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    list_empty |-> (head_slot == '0) && (tail_slot == '0))
    else $error("empty list with head or tail off slot zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result beat overwritten while pending");

  a_insert_link: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !list_full &&
    (command == CMD_INS_FRONT || command == CMD_INS_BACK) |=> state == ST_INS_LINK)
    else $error("insert did not advance to link update");

endmodule

`default_nettype wire

FILE: rtl/cdll_slot_map.sv
// Slot occupancy map with a registered lowest-free-slot finder.
`default_nettype none

module cdll_slot_map
  import cdll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             set,
  input  logic             clear,
  input  logic [IDX_W-1:0] addr,
  output logic [IDX_W-1:0] free_slot
);

  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY-1:0] in_use_next;
  logic [IDX_W-1:0]    free_slot_next;

  always_comb begin
    in_use_next = in_use;
    if (set) begin
      in_use_next[addr] = 1'b1;
    end else if (clear) begin
      in_use_next[addr] = 1'b0;
    end
  end

  always_comb begin
    free_slot_next = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use_next[i]) begin
        free_slot_next = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      free_slot <= '0;
    end else begin
      in_use    <= in_use_next;
      free_slot <= free_slot_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cdll_store.sv
// Slot store: value, next-link and previous-link memories with registered reads.
`default_nettype none

module cdll_store
  import cdll_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  val_we,
  input  logic [IDX_W-1:0]      val_waddr,
  input  logic [DATA_WIDTH-1:0] val_wdata,
  input  logic                  nxt_we,
  input  logic [IDX_W-1:0]      nxt_waddr,
  input  logic [IDX_W-1:0]      nxt_wdata,
  input  logic                  prv_we,
  input  logic [IDX_W-1:0]      prv_waddr,
  input  logic [IDX_W-1:0]      prv_wdata,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] val_rd,
  output logic [IDX_W-1:0]      nxt_rd,
  output logic [IDX_W-1:0]      prv_rd
);

  logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
  logic [IDX_W-1:0]      next_mem  [CAPACITY];
  logic [IDX_W-1:0]      prev_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_waddr] <= val_wdata;
    end
    val_rd <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    nxt_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prev_mem[prv_waddr] <= prv_wdata;
    end
    prv_rd <= prev_mem[rd_addr];
  end

endmodule

`default_nettype wire
